// File: hw/rtl/ffba_pkg.sv
// ffba_pkg: shared constants, types and codes of the first-fit block allocator
// no dependencies; used by the interfaces, the cell, the controller and the top level
`default_nettype none

package ffba_pkg;

    localparam int MEM_UNITS    = 128;
    localparam int HANDLE_WIDTH = 16;

    localparam int IDX_W    = (MEM_UNITS > 1) ? $clog2(MEM_UNITS) : 1;
    localparam int CNT_W    = $clog2(MEM_UNITS + 1);
    localparam int ACTION_W = 2;
    localparam int AMOUNT_W = 16;
    localparam int STATUS_W = 2;
    localparam int HOUT_W   = 16;
    localparam int CFG_W    = 8;

    // common width for mixed compares of sizes, counts and handles
    localparam int CMP_W1 = (AMOUNT_W > CNT_W) ? AMOUNT_W : CNT_W;
    localparam int CMP_W2 = (CMP_W1 > HANDLE_WIDTH) ? CMP_W1 : HANDLE_WIDTH;
    localparam int CMP_W  = (CMP_W2 > CFG_W) ? CMP_W2 : CFG_W;

    localparam logic [CFG_W-1:0]        UNITS_RESET = CFG_W'(128);
    localparam logic [HANDLE_WIDTH-1:0] HANDLE_TOP  = {HANDLE_WIDTH{1'b1}};
    localparam logic [HANDLE_WIDTH-1:0] HANDLE_FIRST = HANDLE_WIDTH'(1);

    typedef logic [HANDLE_WIDTH-1:0] t_owner;
    typedef logic [IDX_W-1:0]        t_idx;
    typedef logic [CNT_W-1:0]        t_cnt;

    typedef enum logic [ACTION_W-1:0] {
        ACT_ALLOC  = 2'd0,
        ACT_ERASE  = 2'd1,
        ACT_DEFRAG = 2'd2,
        ACT_NONE   = 2'd3
    } t_action;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_NULL    = 2'd1,
        ST_ILLEGAL = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_TAG,
        S_SORT,
        S_FIN
    } t_state;

    // chain-wide control from the sequencer
    typedef struct packed {
        logic shift;
        logic swap;
        logic phase;
    } t_chain_ctl;

    // per-cell control
    typedef struct packed {
        logic shift;
        logic take_right;
        logic take_left;
    } t_cell_ctl;

endpackage

`default_nettype wire

// File: hw/rtl/ffba_if.sv
// ffba_in_if / ffba_out_if: valid-ready channels for requests and results
// depends on ffba_pkg for the field widths
`default_nettype none

interface ffba_in_if;
    logic                           valid;
    logic                           ready;
    logic [ffba_pkg::ACTION_W-1:0]  action;
    logic [ffba_pkg::AMOUNT_W-1:0]  amount;

    modport source (output valid, output action, output amount, input ready);
    modport sink   (input valid, input action, input amount, output ready);
endinterface

interface ffba_out_if;
    logic                           valid;
    logic                           ready;
    logic [ffba_pkg::STATUS_W-1:0]  status;
    logic [ffba_pkg::HOUT_W-1:0]    handle;

    modport source (output valid, output status, output handle, input ready);
    modport sink   (input valid, input status, input handle, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/first_fit_block_allocator.sv
// first-fit allocator: MEM_UNITS owner cells rotated past one head, one transaction at a time
// allocate: result after a scan of the chain and then a tagging pass, or after the scan
// alone when no run fits; erase of a handle owning no cell: after the scan; rejected args skip the scan
// next request accepted at the first edge the result can be taken; a result still waiting
// holds the block. legal erase and defragment (MEM_UNITS odd-even swap steps) give no result
// and take the next request once their pass over the chain ends; reset clears every cell, next handle 1
`default_nettype none

module first_fit_block_allocator (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_cfg_wr_en,
    input  wire [ffba_pkg::CFG_W-1:0]   i_cfg_wr_data,
    ffba_in_if.sink                     i_in,
    ffba_out_if.source                  o_out
);

    localparam int N = ffba_pkg::MEM_UNITS;

    ffba_pkg::t_owner       w_val [N];
    ffba_pkg::t_owner       w_tail;
    ffba_pkg::t_chain_ctl   w_ctl;
    ffba_pkg::t_cnt         w_units;

    ffba_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in          (i_in),
        .o_out         (o_out),
        .i_head        (w_val[0]),
        .o_tail        (w_tail),
        .o_ctl         (w_ctl),
        .o_units       (w_units)
    );

    for (genvar k = 0; k < N; k++) begin : g_cell
        ffba_pkg::t_cell_ctl    w_cctl;
        ffba_pkg::t_owner       w_right;
        ffba_pkg::t_owner       w_left;

        if (k == N - 1) begin : g_top
            assign w_right = w_tail;
        end else begin : g_mid
            assign w_right = w_val[k+1];
        end

        if (k == 0) begin : g_bot
            assign w_left            = '0;
            assign w_cctl.take_left  = 1'b0;
        end else begin : g_up
            assign w_left            = w_val[k-1];
            // upper member of a pair whose lower member is k-1
            assign w_cctl.take_left  = w_ctl.swap && (w_ctl.phase == 1'((k - 1) % 2))
                                       && (ffba_pkg::CNT_W'(k) < w_units);
        end

        assign w_cctl.shift      = w_ctl.shift;
        assign w_cctl.take_right = w_ctl.swap && (w_ctl.phase == 1'(k % 2))
                                   && (ffba_pkg::CNT_W'(k + 1) < w_units);

        ffba_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_cctl),
            .i_right (w_right),
            .i_left  (w_left),
            .o_value (w_val[k])
        );
    end

endmodule

`default_nettype wire

// File: hw/rtl/ffba_cell.sv
// ffba_cell: one storage cell of the owner chain, shifts or swaps with its neighbours
// depends on ffba_pkg
`default_nettype none

module ffba_cell (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  ffba_pkg::t_cell_ctl     i_ctl,
    input  ffba_pkg::t_owner        i_right,
    input  ffba_pkg::t_owner        i_left,
    output ffba_pkg::t_owner        o_value
);

    ffba_pkg::t_owner r_value;
    ffba_pkg::t_owner n_value;

    always_comb begin
        n_value = r_value;
        priority if (i_ctl.shift) begin
            n_value = i_right;
        end else if (i_ctl.take_right && (r_value == '0) && (i_right != '0)) begin
            // free cell below an owned one: pull the owner down
            n_value = i_right;
        end else if (i_ctl.take_left && (i_left == '0) && (r_value != '0)) begin
            n_value = i_left;
        end else begin
            n_value = r_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_value <= '0;
        end else begin
            r_value <= n_value;
        end
    end

    assign o_value = r_value;

endmodule

`default_nettype wire

// File: hw/rtl/ffba_ctrl.sv
// ffba_ctrl: sequencer, head-of-chain processing, config register and result register
// depends on ffba_pkg and the ffba_in_if / ffba_out_if interfaces
`default_nettype none

module ffba_ctrl (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_cfg_wr_en,
    input  wire [ffba_pkg::CFG_W-1:0]   i_cfg_wr_data,
    ffba_in_if.sink                     i_in,
    ffba_out_if.source                  o_out,
    input  ffba_pkg::t_owner            i_head,
    output ffba_pkg::t_owner            o_tail,
    output ffba_pkg::t_chain_ctl        o_ctl,
    output ffba_pkg::t_cnt              o_units
);

    localparam int                      CMP_W = ffba_pkg::CMP_W;
    localparam logic [CMP_W-1:0]        MEM_UNITS_W = CMP_W'(ffba_pkg::MEM_UNITS);
    localparam ffba_pkg::t_idx          IDX_LAST = ffba_pkg::IDX_W'(ffba_pkg::MEM_UNITS - 1);

    ffba_pkg::t_state                   r_state, n_state;
    logic [ffba_pkg::CFG_W-1:0]         r_units, n_units;
    ffba_pkg::t_owner                   r_next_handle, n_next_handle;
    ffba_pkg::t_idx                     r_idx, n_idx;
    ffba_pkg::t_cnt                     r_run, n_run;
    logic                               r_found, n_found;
    ffba_pkg::t_idx                     r_start, n_start;
    ffba_pkg::t_idx                     r_end, n_end;
    ffba_pkg::t_action                  r_op, n_op;
    logic [ffba_pkg::AMOUNT_W-1:0]      r_arg, n_arg;
    ffba_pkg::t_status                  r_res_status, n_res_status;
    logic [ffba_pkg::HOUT_W-1:0]        r_res_handle, n_res_handle;
    logic                               r_out_valid, n_out_valid;
    ffba_pkg::t_status                  r_out_status, n_out_status;
    logic [ffba_pkg::HOUT_W-1:0]        r_out_handle, n_out_handle;

    ffba_pkg::t_cnt                     w_units;
    logic [CMP_W-1:0]                   w_units_c;
    logic [CMP_W-1:0]                   w_arg_c;
    logic [CMP_W-1:0]                   w_amount_c;
    logic                               w_accept;
    logic                               w_alloc_ok;
    logic                               w_erase_ok;
    logic                               w_in_range;
    logic                               w_last;
    ffba_pkg::t_cnt                     w_run_n;
    logic                               w_fit;
    logic                               w_hit;
    logic                               w_tag;
    logic                               w_load;

    // effective number of managed cells
    assign w_units   = (CMP_W'(r_units) < MEM_UNITS_W) ? ffba_pkg::CNT_W'(r_units)
                                                       : ffba_pkg::CNT_W'(ffba_pkg::MEM_UNITS);
    assign w_units_c = CMP_W'(w_units);
    assign o_units   = w_units;

    assign w_accept   = i_in.valid && i_in.ready;
    assign w_amount_c = CMP_W'(i_in.amount);
    assign w_arg_c    = CMP_W'(r_arg);
    assign w_alloc_ok = (i_in.amount != '0) && (w_amount_c <= w_units_c)
                        && (r_next_handle != ffba_pkg::HANDLE_TOP);
    assign w_erase_ok = (i_in.amount != '0) && (w_amount_c < CMP_W'(r_next_handle));

    // head of chain sees address r_idx
    assign w_in_range = CMP_W'(r_idx) < w_units_c;
    assign w_last     = (r_idx == IDX_LAST);
    assign w_run_n    = (i_head == '0) ? (r_run + ffba_pkg::CNT_W'(1)) : '0;
    assign w_fit      = (r_op == ffba_pkg::ACT_ALLOC) && w_in_range && !r_found
                        && (CMP_W'(w_run_n) >= w_arg_c);
    assign w_hit      = (r_op == ffba_pkg::ACT_ERASE) && w_in_range
                        && (CMP_W'(i_head) == w_arg_c);
    assign w_tag      = (r_idx >= r_start) && (r_idx <= r_end);
    assign w_load     = (r_state == ffba_pkg::S_FIN) && (!r_out_valid || o_out.ready);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ffba_pkg::S_IDLE: begin
                if (w_accept) begin
                    unique case (ffba_pkg::t_action'(i_in.action))
                        ffba_pkg::ACT_ALLOC:  n_state = w_alloc_ok ? ffba_pkg::S_SCAN
                                                                   : ffba_pkg::S_FIN;
                        ffba_pkg::ACT_ERASE:  n_state = w_erase_ok ? ffba_pkg::S_SCAN
                                                                   : ffba_pkg::S_FIN;
                        ffba_pkg::ACT_DEFRAG: n_state = ffba_pkg::S_SORT;
                        ffba_pkg::ACT_NONE:   n_state = ffba_pkg::S_IDLE;
                        default:              n_state = ffba_pkg::S_IDLE;
                    endcase
                end
            end
            ffba_pkg::S_SCAN: begin
                if (w_last) begin
                    if (r_op == ffba_pkg::ACT_ALLOC) begin
                        n_state = (r_found || w_fit) ? ffba_pkg::S_TAG : ffba_pkg::S_FIN;
                    end else begin
                        n_state = (r_found || w_hit) ? ffba_pkg::S_IDLE : ffba_pkg::S_FIN;
                    end
                end
            end
            ffba_pkg::S_TAG: begin
                if (w_last) begin
                    n_state = ffba_pkg::S_FIN;
                end
            end
            ffba_pkg::S_SORT: begin
                if (w_last) begin
                    n_state = ffba_pkg::S_IDLE;
                end
            end
            ffba_pkg::S_FIN: begin
                if (w_load) begin
                    n_state = ffba_pkg::S_IDLE;
                end
            end
            default: n_state = ffba_pkg::S_IDLE;
        endcase
    end

    // outputs to the chain and the request channel
    always_comb begin
        i_in.ready  = 1'b0;
        o_ctl       = '0;
        o_tail      = i_head;
        unique case (r_state)
            ffba_pkg::S_IDLE: begin
                i_in.ready = 1'b1;
            end
            ffba_pkg::S_SCAN: begin
                o_ctl.shift = 1'b1;
                o_tail      = w_hit ? '0 : i_head;
            end
            ffba_pkg::S_TAG: begin
                o_ctl.shift = 1'b1;
                o_tail      = w_tag ? r_next_handle : i_head;
            end
            ffba_pkg::S_SORT: begin
                o_ctl.swap  = 1'b1;
                o_ctl.phase = r_idx[0];
            end
            ffba_pkg::S_FIN: begin
                o_ctl = '0;
            end
            default: o_ctl = '0;
        endcase
    end

    // datapath next values
    always_comb begin
        n_units       = r_units;
        n_next_handle = r_next_handle;
        n_idx         = r_idx;
        n_run         = r_run;
        n_found       = r_found;
        n_start       = r_start;
        n_end         = r_end;
        n_op          = r_op;
        n_arg         = r_arg;
        n_res_status  = r_res_status;
        n_res_handle  = r_res_handle;
        n_out_status  = r_out_status;
        n_out_handle  = r_out_handle;
        n_out_valid   = r_out_valid && !o_out.ready;

        if (i_cfg_wr_en) begin
            n_units = i_cfg_wr_data;
        end

        unique case (r_state)
            ffba_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_op         = ffba_pkg::t_action'(i_in.action);
                    n_arg        = i_in.amount;
                    n_idx        = '0;
                    n_run        = '0;
                    n_found      = 1'b0;
                    n_res_handle = '0;
                    n_res_status = (ffba_pkg::t_action'(i_in.action) == ffba_pkg::ACT_ERASE)
                                   ? ffba_pkg::ST_ILLEGAL : ffba_pkg::ST_NULL;
                end
            end
            ffba_pkg::S_SCAN: begin
                n_idx = w_last ? '0 : (r_idx + ffba_pkg::IDX_W'(1));
                if (w_in_range) begin
                    n_run = w_run_n;
                end
                if (w_fit) begin
                    n_found = 1'b1;
                    n_end   = r_idx;
                    n_start = ffba_pkg::IDX_W'(CMP_W'(r_idx) + CMP_W'(1) - w_arg_c);
                end
                if (w_hit) begin
                    n_found = 1'b1;
                end
            end
            ffba_pkg::S_TAG: begin
                n_idx = w_last ? '0 : (r_idx + ffba_pkg::IDX_W'(1));
                if (w_last) begin
                    n_res_status  = ffba_pkg::ST_OK;
                    n_res_handle  = ffba_pkg::HOUT_W'(r_next_handle);
                    n_next_handle = r_next_handle + ffba_pkg::HANDLE_WIDTH'(1);
                end
            end
            ffba_pkg::S_SORT: begin
                n_idx = w_last ? '0 : (r_idx + ffba_pkg::IDX_W'(1));
            end
            ffba_pkg::S_FIN: begin
                if (w_load) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_handle = r_res_handle;
                end
            end
            default: n_idx = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ffba_pkg::S_IDLE;
            r_units       <= ffba_pkg::UNITS_RESET;
            r_next_handle <= ffba_pkg::HANDLE_FIRST;
            r_idx         <= '0;
            r_found       <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_units       <= n_units;
            r_next_handle <= n_next_handle;
            r_idx         <= n_idx;
            r_found       <= n_found;
            r_out_valid   <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_run        <= n_run;
        r_start      <= n_start;
        r_end        <= n_end;
        r_op         <= n_op;
        r_arg        <= n_arg;
        r_res_status <= n_res_status;
        r_res_handle <= n_res_handle;
        r_out_status <= n_out_status;
        r_out_handle <= n_out_handle;
    end

    assign o_out.valid  = r_out_valid;
    assign o_out.status = r_out_status;
    assign o_out.handle = r_out_handle;

    a_ctl_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_ctl.shift && o_ctl.swap))
        else $error("chain shift and swap requested together");

    a_tag_after_fit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ffba_pkg::S_TAG) |-> r_found)
        else $error("tagging pass without a fitting run");

    a_handle_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> (r_next_handle >= $past(r_next_handle)))
        else $error("handle counter went backwards");

    a_ok_has_handle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_status == ffba_pkg::ST_OK)) |-> (r_out_handle != '0))
        else $error("successful allocation without a handle");

endmodule

`default_nettype wire

// File: tb/ffba_cell_map_checker.sv
// ffba_cell_map_checker: watches the request and result channels of the allocator,
// keeps its own copy of the cell owner map and the handle counter, and checks every result
// depends on ffba_pkg and the channel interfaces in ffba_if.sv
`default_nettype none

module ffba_cell_map_checker (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_cfg_wr_en,
    input  wire [ffba_pkg::CFG_W-1:0]   i_cfg_wr_data,
    ffba_in_if                          req,
    ffba_out_if                         rsp,
    output int                          o_mismatches,
    output int                          o_replies_due
);
    import ffba_pkg::*;

    typedef struct packed {
        t_status                status;
        logic [HOUT_W-1:0]      handle;
    } t_reply;

    t_owner                 cell_tag [MEM_UNITS];
    t_owner                 handle_next;
    logic [CFG_W-1:0]       units_reg;
    t_reply                 replies_due [$];
    int                     mismatches = 0;
    int                     replies_left = 0;

    assign o_mismatches  = mismatches;
    assign o_replies_due = replies_left;

    function automatic int managed_cells();
        return (int'(units_reg) < MEM_UNITS) ? int'(units_reg) : MEM_UNITS;
    endfunction

    // applies one request to the owner map and queues the reply it causes
    task automatic track_request(input t_action act, input logic [AMOUNT_W-1:0] amt);
        int     lim;
        int     run;
        int     dst;
        int     i;
        int     k;
        bit     done;
        bit     found;
        t_reply reply;
        lim = managed_cells();
        reply.status = ST_NULL;
        reply.handle = '0;
        case (act)
            ACT_ALLOC: begin
                if (amt != 0 && int'(amt) <= lim && handle_next != HANDLE_TOP) begin
                    run  = 0;
                    done = 1'b0;
                    for (i = 0; i < lim && !done; i++) begin
                        run = (cell_tag[i] == '0) ? run + 1 : 0;
                        if (run >= int'(amt)) begin
                            for (k = i + 1 - int'(amt); k <= i; k++)
                                cell_tag[k] = handle_next;
                            reply.status = ST_OK;
                            reply.handle = HOUT_W'(handle_next);
                            handle_next  = handle_next + 1'b1;
                            done = 1'b1;
                        end
                    end
                end
                replies_due.push_back(reply);
            end
            ACT_ERASE: begin
                found = 1'b0;
                if (amt != 0 && int'(amt) < int'(handle_next)) begin
                    for (i = 0; i < lim; i++) begin
                        if (cell_tag[i] == t_owner'(amt)) begin
                            cell_tag[i] = '0;
                            found = 1'b1;
                        end
                    end
                end
                if (!found) begin
                    reply.status = ST_ILLEGAL;
                    replies_due.push_back(reply);
                end
            end
            ACT_DEFRAG: begin
                dst = 0;
                for (i = 0; i < lim; i++) begin
                    if (cell_tag[i] != '0) begin
                        cell_tag[dst] = cell_tag[i];
                        dst++;
                    end
                end
                for (i = dst; i < lim; i++)
                    cell_tag[i] = '0;
            end
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin
        t_reply due;
        if (!i_rst_n) begin
            for (int i = 0; i < MEM_UNITS; i++)
                cell_tag[i] = '0;
            handle_next = HANDLE_FIRST;
            units_reg   = UNITS_RESET;
            replies_due.delete();
        end else begin
            if (rsp.valid && rsp.ready) begin
                if (replies_due.size() == 0) begin
                    if (mismatches < 10)
                        $display("unexpected result: status %0d handle %0d",
                                 rsp.status, rsp.handle);
                    mismatches++;
                end else begin
                    due = replies_due.pop_front();
                    if (t_status'(rsp.status) !== due.status || rsp.handle !== due.handle) begin
                        if (mismatches < 10)
                            $display("result mismatch: status exp %0d got %0d, handle exp %0d got %0d",
                                     due.status, rsp.status, due.handle, rsp.handle);
                        mismatches++;
                    end
                end
            end
            if (i_cfg_wr_en)
                units_reg = i_cfg_wr_data;
            if (req.valid && req.ready)
                track_request(t_action'(req.action), req.amount);
        end
        replies_left <= replies_due.size();
    end

endmodule

`default_nettype wire

// File: tb/tb_first_fit_block_allocator.sv
// tb_first_fit_block_allocator: clock, reset, register writes and request stimulus
// for the allocator; results are checked by ffba_cell_map_checker
// depends on ffba_pkg, ffba_if.sv, first_fit_block_allocator and the checker
`default_nettype none

module tb_first_fit_block_allocator;
    import ffba_pkg::*;

    localparam int CYCLE_LIMIT   = 2000000;
    localparam int SETTLE_CYCLES = 400;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   cfg_wr_en;
    logic [CFG_W-1:0]       cfg_wr_data;
    int                     fail_count;
    int                     replies_due;
    int                     send_idle;
    int                     recv_idle;
    int                     cycle_count;
    logic [HOUT_W-1:0]      granted [$];
    logic [HOUT_W-1:0]      live [$];
    int                     granted_seen;

    ffba_in_if  req_ch ();
    ffba_out_if rsp_ch ();

    first_fit_block_allocator dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (cfg_wr_en),
        .i_cfg_wr_data  (cfg_wr_data),
        .i_in           (req_ch),
        .o_out          (rsp_ch)
    );

    ffba_cell_map_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (cfg_wr_en),
        .i_cfg_wr_data  (cfg_wr_data),
        .req            (req_ch),
        .rsp            (rsp_ch),
        .o_mismatches   (fail_count),
        .o_replies_due  (replies_due)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    // result side back-pressure
    initial begin
        rsp_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            rsp_ch.ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    // handles granted so far, so that erases can aim at live blocks
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready && t_status'(rsp_ch.status) == ST_OK)
            granted.push_back(rsp_ch.handle);
    end

    task automatic offer(input t_action act, input logic [AMOUNT_W-1:0] amt);
        if (send_idle > 0 && $urandom_range(99) < send_idle) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < send_idle)
                @(posedge i_clk);
        end
        req_ch.valid  <= 1'b1;
        req_ch.action <= act;
        req_ch.amount <= amt;
        @(posedge i_clk);
        while (!req_ch.ready)
            @(posedge i_clk);
    endtask

    // hold off requests until every due result is back, then let the block settle
    task automatic drain(input int tail);
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (replies_due != 0)
            @(posedge i_clk);
        repeat (tail) @(posedge i_clk);
    endtask

    task automatic write_units(input logic [CFG_W-1:0] value);
        drain(SETTLE_CYCLES);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge i_clk);
        cfg_wr_en   <= 1'b0;
    endtask

    task automatic random_request();
        int                 pick;
        int                 idx;
        logic [HOUT_W-1:0]  h;
        while (granted_seen < granted.size()) begin
            live.push_back(granted[granted_seen]);
            granted_seen++;
        end
        pick = $urandom_range(99);
        if (pick < 80 && pick >= 50 && live.size() == 0)
            pick = 0;
        if (pick < 50) begin
            if ($urandom_range(9) == 0)
                offer(ACT_ALLOC, AMOUNT_W'($urandom_range(1, MEM_UNITS)));
            else
                offer(ACT_ALLOC, AMOUNT_W'($urandom_range(1, 8)));
        end else if (pick < 80) begin
            idx = $urandom_range(live.size() - 1);
            h = live[idx];
            live.delete(idx);
            offer(ACT_ERASE, AMOUNT_W'(h));
        end else if (pick < 88) begin
            offer(ACT_DEFRAG, AMOUNT_W'($urandom));
        end else begin
            case ($urandom_range(4))
                0: offer(ACT_ALLOC, AMOUNT_W'($urandom));
                1: offer(ACT_ERASE, AMOUNT_W'($urandom));
                2: offer(ACT_NONE, AMOUNT_W'($urandom));
                3: offer(ACT_ERASE, '0);
                default: offer(ACT_ALLOC, '0);
            endcase
        end
    endtask

    initial begin
        int n_items;
        logic [CFG_W-1:0] units;
        i_rst_n       <= 1'b0;
        cfg_wr_en     <= 1'b0;
        cfg_wr_data   <= '0;
        req_ch.valid  <= 1'b0;
        req_ch.action <= ACT_ALLOC;
        req_ch.amount <= '0;
        granted_seen  = 0;
        send_idle     = 23;
        recv_idle     = 63;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: rejected sizes, illegal erases, ignored action, fill and compaction
        offer(ACT_ALLOC, 16'd0);
        offer(ACT_ALLOC, 16'd129);
        offer(ACT_ALLOC, 16'hFFFF);
        offer(ACT_ERASE, 16'd0);
        offer(ACT_ERASE, 16'd1);
        offer(ACT_NONE, 16'hFFFF);
        offer(ACT_ALLOC, 16'd1);
        offer(ACT_ALLOC, 16'd3);
        offer(ACT_ALLOC, 16'd2);
        offer(ACT_ERASE, 16'd2);
        offer(ACT_ERASE, 16'd2);
        offer(ACT_ALLOC, 16'd4);
        offer(ACT_DEFRAG, 16'hFFFF);
        offer(ACT_ALLOC, 16'd121);
        offer(ACT_ALLOC, 16'd1);
        offer(ACT_ERASE, 16'hFFFF);
        offer(ACT_DEFRAG, 16'd0);
        offer(ACT_ERASE, 16'd5);
        offer(ACT_ALLOC, 16'd128);

        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: units = 8'd128;
                1: units = 8'd255;
                2: units = 8'd1;
                3: units = 8'd0;
                4: units = CFG_W'($urandom_range(2, 127));
                default: units = 8'd128;
            endcase
            write_units(units);
            if (phase < 2) begin
                send_idle = 23;
                recv_idle = 63;
            end else if (phase < 4) begin
                send_idle = 63;
                recv_idle = 23;
            end else begin
                send_idle = 0;
                recv_idle = 0;
            end
            n_items = (phase == 3) ? 25 : 115;
            for (int i = 0; i < n_items; i++) begin
                if ($urandom_range(99) == 0)
                    drain(0);
                random_request();
            end
        end

        drain(SETTLE_CYCLES);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

`default_nettype wire

// File: first_fit_block_allocator.f
hw/rtl/ffba_pkg.sv
hw/rtl/ffba_if.sv
hw/rtl/ffba_cell.sv
hw/rtl/ffba_ctrl.sv
hw/rtl/first_fit_block_allocator.sv
tb/ffba_cell_map_checker.sv
tb/tb_first_fit_block_allocator.sv
